// File: hw/rtl/cbc_pkg.sv
// Shared constants, codes and types for the cartridge bank controller.
// Used by every module in this folder; it depends on nothing.
package cbc_pkg;

    localparam int ROM_BYTES_DEF = 1048576;
    localparam int RAM_BYTES_DEF = 32768;

    localparam int OP_W        = 3;
    localparam int BUS_ADDR_W  = 15;
    localparam int BYTE_W      = 8;
    localparam int LOAD_ADDR_W = 20;
    localparam int KIND_W      = 2;
    localparam int RAM_SIZE_W  = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int ROM_BANK_W  = 9;
    localparam int RAM_BANK_W  = 4;
    localparam int ROM_FULL_W  = 23;
    localparam int RAM_OFF_W   = 17;

    localparam logic [OP_W-1:0] OP_ROM_READ = 3'd0;
    localparam logic [OP_W-1:0] OP_CTRL_WR  = 3'd1;
    localparam logic [OP_W-1:0] OP_RAM_READ = 3'd2;
    localparam logic [OP_W-1:0] OP_RAM_WR   = 3'd3;
    localparam logic [OP_W-1:0] OP_ROM_LOAD = 3'd4;

    localparam logic [KIND_W-1:0] MAP_NONE = 2'd0;
    localparam logic [KIND_W-1:0] MAP_MBC1 = 2'd1;
    localparam logic [KIND_W-1:0] MAP_MBC3 = 2'd2;
    localparam logic [KIND_W-1:0] MAP_MBC5 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BYTES   = 2'd1;

    localparam logic [1:0] SRC_ROM = 2'd0;
    localparam logic [1:0] SRC_RAM = 2'd1;
    localparam logic [1:0] SRC_FF  = 2'd2;

    localparam logic [1:0] REG_GATE = 2'b00;
    localparam logic [1:0] REG_BANK = 2'b01;
    localparam logic [1:0] REG_HIGH = 2'b10;
    localparam logic [1:0] REG_MODE = 2'b11;

    localparam logic [BYTE_W-1:0] BLOCKED_BYTE = 8'hFF;
    localparam logic [3:0]        GATE_KEY     = 4'hA;

    typedef struct packed {
        logic [ROM_FULL_W-1:0] rom_addr;
        logic [RAM_OFF_W-1:0]  ram_off;
        logic                  ram_ok;
    } t_map_out;

endpackage

// File: hw/rtl/cbc_mapper.sv
// Mapper bank registers, control write decode and ROM/RAM address generation.
// Depends on cbc_pkg.
module cbc_mapper #(
    parameter int RAM_BYTES = cbc_pkg::RAM_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [cbc_pkg::KIND_W-1:0]       i_mapper_kind,
    input  logic [cbc_pkg::RAM_SIZE_W-1:0]   i_ram_bytes,
    input  logic [cbc_pkg::BUS_ADDR_W-1:0]   i_bus_address,
    input  logic [cbc_pkg::BYTE_W-1:0]       i_write_value,
    output cbc_pkg::t_map_out                o_map
);

    localparam logic [cbc_pkg::RAM_SIZE_W-1:0] RAM_LIM = cbc_pkg::RAM_SIZE_W'(RAM_BYTES);

    logic [cbc_pkg::ROM_BANK_W-1:0] r_rom_bank, n_rom_bank;
    logic [cbc_pkg::RAM_BANK_W-1:0] r_ram_bank, n_ram_bank;
    logic                           r_gate, n_gate;
    logic                           r_mode, n_mode;
    logic [4:0]                     low5;
    logic [6:0]                     low7;
    logic [1:0]                     region;
    logic [cbc_pkg::RAM_SIZE_W-1:0] ram_off_ext;

    assign region = i_bus_address[14:13];
    assign low5   = (i_write_value[4:0] == 5'd0) ? 5'd1 : i_write_value[4:0];
    assign low7   = (i_write_value[6:0] == 7'd0) ? 7'd1 : i_write_value[6:0];

    always_comb begin
        n_rom_bank = r_rom_bank;
        n_ram_bank = r_ram_bank;
        n_gate     = r_gate;
        n_mode     = r_mode;
        if (i_wr_en && (i_mapper_kind != cbc_pkg::MAP_NONE)) begin
            if (region == cbc_pkg::REG_GATE) begin
                n_gate = (i_write_value[3:0] == cbc_pkg::GATE_KEY);
            end else begin
                case (i_mapper_kind)
                    cbc_pkg::MAP_MBC1: begin
                        case (region)
                            cbc_pkg::REG_BANK: n_rom_bank = {2'b00, r_rom_bank[6:5], low5};
                            cbc_pkg::REG_HIGH: begin
                                if (!r_mode) begin
                                    n_rom_bank = {2'b00, i_write_value[1:0], r_rom_bank[4:0]};
                                end else begin
                                    n_ram_bank = {2'b00, i_write_value[1:0]};
                                end
                            end
                            default: n_mode = i_write_value[0];
                        endcase
                    end
                    cbc_pkg::MAP_MBC3: begin
                        case (region)
                            cbc_pkg::REG_BANK: n_rom_bank = {2'b00, low7};
                            cbc_pkg::REG_HIGH: n_ram_bank = i_write_value[3:0];
                            default: n_ram_bank = r_ram_bank;
                        endcase
                    end
                    default: begin
                        case (region)
                            cbc_pkg::REG_BANK: begin
                                if (!i_bus_address[12]) begin
                                    n_rom_bank = {r_rom_bank[8], i_write_value};
                                end else begin
                                    n_rom_bank = {i_write_value[0], r_rom_bank[7:0]};
                                end
                            end
                            cbc_pkg::REG_HIGH: n_ram_bank = i_write_value[3:0];
                            default: n_ram_bank = r_ram_bank;
                        endcase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank <= cbc_pkg::ROM_BANK_W'(1);
            r_ram_bank <= '0;
            r_gate     <= 1'b0;
            r_mode     <= 1'b0;
        end else begin
            r_rom_bank <= n_rom_bank;
            r_ram_bank <= n_ram_bank;
            r_gate     <= n_gate;
            r_mode     <= n_mode;
        end
    end

    // Addresses below 0x4000 always hit bank 0.
    assign o_map.rom_addr = {r_rom_bank & {cbc_pkg::ROM_BANK_W{i_bus_address[14]}},
                             i_bus_address[13:0]};
    assign o_map.ram_off  = {r_ram_bank, i_bus_address[12:0]};
    assign ram_off_ext    = {1'b0, o_map.ram_off};
    assign o_map.ram_ok   = r_gate && (ram_off_ext < i_ram_bytes) && (ram_off_ext < RAM_LIM);

    a_mbc1_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && i_mapper_kind == cbc_pkg::MAP_MBC1 && region == cbc_pkg::REG_BANK)
        |=> (r_rom_bank[4:0] != 5'd0))
        else $error("MBC1 low bank bits written as zero");

    a_mbc3_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && i_mapper_kind == cbc_pkg::MAP_MBC3 && region == cbc_pkg::REG_BANK)
        |=> (r_rom_bank != '0))
        else $error("MBC3 bank written as zero");

    a_none_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && i_mapper_kind == cbc_pkg::MAP_NONE)
        |=> ($stable(r_rom_bank) && $stable(r_ram_bank) && $stable(r_gate) && $stable(r_mode)))
        else $error("Mapper state changed without a mapper");

endmodule

// File: hw/rtl/cbc_rom.sv
// ROM store: one write port for loads, one registered read port.
// Depends on cbc_pkg.
module cbc_rom #(
    parameter int ROM_BYTES = cbc_pkg::ROM_BYTES_DEF,
    localparam int ROM_AW   = $clog2(ROM_BYTES)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [ROM_AW-1:0]             i_waddr,
    input  logic [cbc_pkg::BYTE_W-1:0]    i_wdata,
    input  logic                          i_re,
    input  logic [ROM_AW-1:0]             i_raddr,
    output logic [cbc_pkg::BYTE_W-1:0]    o_rdata
);

    logic [cbc_pkg::BYTE_W-1:0] r_mem [ROM_BYTES];
    logic [cbc_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/cbc_ram.sv
// Cartridge RAM store with a zero-fill sweep after reset and a registered read.
// Depends on cbc_pkg.
module cbc_ram #(
    parameter int RAM_BYTES = cbc_pkg::RAM_BYTES_DEF,
    localparam int RAM_AW   = $clog2(RAM_BYTES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic                          i_re,
    input  logic [RAM_AW-1:0]             i_addr,
    input  logic [cbc_pkg::BYTE_W-1:0]    i_wdata,
    output logic [cbc_pkg::BYTE_W-1:0]    o_rdata,
    output logic                          o_busy
);

    localparam logic [RAM_AW-1:0] LAST = RAM_AW'(RAM_BYTES - 1);

    logic [cbc_pkg::BYTE_W-1:0] r_mem [RAM_BYTES];
    logic [cbc_pkg::BYTE_W-1:0] r_rdata;
    logic                       r_busy;
    logic [RAM_AW-1:0]          r_clr_addr;
    logic                       we;
    logic [RAM_AW-1:0]          waddr;
    logic [cbc_pkg::BYTE_W-1:0] wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign we    = r_busy || i_we;
    assign waddr = r_busy ? r_clr_addr : i_addr;
    assign wdata = r_busy ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

// File: hw/rtl/cartridge_bank_controller_top.sv
// Cartridge bank controller top level: handshakes, configuration and result register.
// Read path: the memory read register and pending flag, then the result register.
// Throughput: one word per cycle while results are taken; a stalled result holds input.
// Reset: the RAM sweep writes zeros to every RAM byte with input not ready.
// ROM_BYTES must be a power of two, which the block does not check; ROM contents survive reset.
// Depends on cbc_pkg, cbc_mapper, cbc_rom and cbc_ram.
module cartridge_bank_controller_top #(
    parameter int ROM_BYTES = cbc_pkg::ROM_BYTES_DEF,
    parameter int RAM_BYTES = cbc_pkg::RAM_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cbc_pkg::RAM_SIZE_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [cbc_pkg::OP_W-1:0]          i_operation,
    input  logic [cbc_pkg::BUS_ADDR_W-1:0]    i_bus_address,
    input  logic [cbc_pkg::BYTE_W-1:0]        i_write_value,
    input  logic [cbc_pkg::LOAD_ADDR_W-1:0]   i_load_address,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [cbc_pkg::BYTE_W-1:0]        o_read_data
);

    localparam int ROM_AW = $clog2(ROM_BYTES);
    localparam int RAM_AW = $clog2(RAM_BYTES);

    logic [cbc_pkg::KIND_W-1:0]     r_mapper_kind;
    logic [cbc_pkg::RAM_SIZE_W-1:0] r_ram_bytes;
    logic                           r_pend;
    logic [1:0]                     r_pend_sel;
    logic                           r_out_valid;
    logic [cbc_pkg::BYTE_W-1:0]     r_read_data;

    cbc_pkg::t_map_out              map;
    logic                           in_acc;
    logic                           pend_move;
    logic                           ram_busy;
    logic                           is_rom_rd;
    logic                           is_ram_rd;
    logic                           is_ram_wr;
    logic                           is_load;
    logic [cbc_pkg::ROM_FULL_W-1:0] load_full;
    logic [cbc_pkg::BYTE_W-1:0]     rom_rdata;
    logic [cbc_pkg::BYTE_W-1:0]     ram_rdata;
    logic [cbc_pkg::BYTE_W-1:0]     pend_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper_kind <= cbc_pkg::MAP_NONE;
            r_ram_bytes   <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == cbc_pkg::CFG_MAPPER_KIND) begin
                r_mapper_kind <= i_cfg_data[cbc_pkg::KIND_W-1:0];
            end else if (i_cfg_index == cbc_pkg::CFG_RAM_BYTES) begin
                r_ram_bytes <= i_cfg_data;
            end
        end
    end

    assign pend_move  = !r_out_valid || i_out_ready;
    assign o_in_ready = !ram_busy && (!r_pend || pend_move);
    assign in_acc     = i_in_valid && o_in_ready;

    assign is_rom_rd = in_acc && (i_operation == cbc_pkg::OP_ROM_READ);
    assign is_ram_rd = in_acc && (i_operation == cbc_pkg::OP_RAM_READ);
    assign is_ram_wr = in_acc && (i_operation == cbc_pkg::OP_RAM_WR) && map.ram_ok;
    assign is_load   = in_acc && (i_operation == cbc_pkg::OP_ROM_LOAD);
    assign load_full = cbc_pkg::ROM_FULL_W'(i_load_address);

    cbc_mapper #(
        .RAM_BYTES (RAM_BYTES)
    ) u_mapper (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (in_acc && (i_operation == cbc_pkg::OP_CTRL_WR)),
        .i_mapper_kind (r_mapper_kind),
        .i_ram_bytes   (r_ram_bytes),
        .i_bus_address (i_bus_address),
        .i_write_value (i_write_value),
        .o_map         (map)
    );

    cbc_rom #(
        .ROM_BYTES (ROM_BYTES)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (is_load),
        .i_waddr (load_full[ROM_AW-1:0]),
        .i_wdata (i_write_value),
        .i_re    (is_rom_rd),
        .i_raddr (map.rom_addr[ROM_AW-1:0]),
        .o_rdata (rom_rdata)
    );

    cbc_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (is_ram_wr),
        .i_re    (is_ram_rd && map.ram_ok),
        .i_addr  (map.ram_off[RAM_AW-1:0]),
        .i_wdata (i_write_value),
        .o_rdata (ram_rdata),
        .o_busy  (ram_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (in_acc) begin
            r_pend <= is_rom_rd || is_ram_rd;
        end else if (pend_move) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_rom_rd) begin
            r_pend_sel <= cbc_pkg::SRC_ROM;
        end else if (is_ram_rd) begin
            r_pend_sel <= map.ram_ok ? cbc_pkg::SRC_RAM : cbc_pkg::SRC_FF;
        end
    end

    always_comb begin
        case (r_pend_sel)
            cbc_pkg::SRC_ROM: pend_data = rom_rdata;
            cbc_pkg::SRC_RAM: pend_data = ram_rdata;
            default:          pend_data = cbc_pkg::BLOCKED_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend && pend_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && pend_move) begin
            r_read_data <= pend_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

    a_read_goes_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_rom_rd || is_ram_rd) |=> r_pend)
        else $error("Accepted read did not reach the pending stage");

    a_pending_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !pend_move) |=> (r_pend && $stable(r_pend_sel)))
        else $error("Stalled pending read was lost");

    a_result_from_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_pend))
        else $error("Result appeared without a pending read");

    a_no_access_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_busy |-> !(is_ram_wr || is_load || is_rom_rd || is_ram_rd))
        else $error("Memory access during the RAM clearing sweep");

endmodule
